>>> hdl/chacha_pkg.sv
// Shared constants and types for the ChaCha20 stream cipher.
`default_nettype none

package chacha_pkg;

  typedef logic [31:0] word_t;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int DR_W          = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES) + 1;

  // Register indexes on the configuration port
  localparam int          CFG_IDX_W   = 3;
  localparam int          CFG_DATA_W  = 64;
  localparam logic [2:0]  REG_KEY_01  = 3'd0;
  localparam logic [2:0]  REG_KEY_23  = 3'd1;
  localparam logic [2:0]  REG_KEY_45  = 3'd2;
  localparam logic [2:0]  REG_KEY_67  = 3'd3;
  localparam logic [2:0]  REG_NONCE_L = 3'd4;
  localparam logic [2:0]  REG_NONCE_H = 3'd5;
  localparam logic [2:0]  REG_INIT_CT = 3'd6;

endpackage

`default_nettype wire

>>> hdl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: byte stream XOR with keystream.
`default_nettype none

// Channel  Dir  Signals                                Carries
// s_       in   s_tvalid s_tready s_tdata s_tuser s_tlast  data_byte, restart, last_in
// m_       out  m_tvalid m_tready m_tdata m_tlast         out_byte, last_out
// cfg_     in   cfg_we cfg_index cfg_data                 register writes, no handshake
//
// A byte that finds keystream left in the buffer is accepted, then emitted.
// A byte that needs a new block first waits for load, DOUBLE_ROUNDS double rounds
// (ten) and the feed-forward: the single 32-bit adder does one add/xor/rotate
// micro-step per cycle, four per quarter round, then sixteen feed-forward adds.
// Reset: synchronous, active high; the buffer starts empty, counter at zero.
// A stalled output holds the result register; the next byte is still accepted
// and waits in the emit step until the register frees.

module chacha20_stream_cipher (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave stream
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  wire logic                               s_tuser,   // [0] restart
  input  wire logic                               s_tlast,   // last_in
  // master stream
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  output      logic [7:0]                         m_tdata,   // [7:0] out_byte
  output      logic                               m_tlast,   // last_out
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import chacha_pkg::*;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FF    = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state;

  // Configuration registers
  logic [63:0] key_01, key_23, key_45, key_67, nonce_low;
  logic [31:0] nonce_high, init_counter;

  // Stream state
  logic [31:0]      block_counter;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       data_hold;
  logic             last_hold;

  // Working state, which also holds the finished keystream block
  word_t w [16];
  word_t w_round [16];
  word_t w_ff [16];
  word_t init_w [16];

  // Sequencer counters: micro-step, quarter round, double round, feed-forward
  logic [1:0]      sub;
  logic [2:0]      qr;
  logic [DR_W-1:0] dr;
  logic [3:0]      ff_cnt;

  word_t op_a, op_b, sum;
  word_t mixed;
  logic  round_done;
  word_t ks_word;
  logic [7:0] ks_byte;

  assign s_tready = (state == S_IDLE);

  // Input state of a block, from the registers and the counter
  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    init_w[4]  = key_01[31:0];
    init_w[5]  = key_01[63:32];
    init_w[6]  = key_23[31:0];
    init_w[7]  = key_23[63:32];
    init_w[8]  = key_45[31:0];
    init_w[9]  = key_45[63:32];
    init_w[10] = key_67[31:0];
    init_w[11] = key_67[63:32];
    init_w[12] = block_counter;
    init_w[13] = nonce_low[31:0];
    init_w[14] = nonce_low[63:32];
    init_w[15] = nonce_high;
  end

  // The shared adder: quarter-round add during rounds, feed-forward add after
  always_comb begin
    if (state == S_FF) begin
      op_a = w[0];
      op_b = init_w[ff_cnt];
    end else if (sub[0]) begin
      op_a = w[8];
      op_b = w[12];
    end else begin
      op_a = w[0];
      op_b = w[4];
    end
  end

  assign sum = op_a + op_b;

  // Xor and rotate that follow the add
  always_comb begin
    word_t t;
    t = sub[0] ? (w[4] ^ sum) : (w[12] ^ sum);
    unique case (sub)
      2'd0:    mixed = {t[15:0], t[31:16]};
      2'd1:    mixed = {t[19:0], t[31:20]};
      2'd2:    mixed = {t[23:0], t[31:24]};
      default: mixed = {t[24:0], t[31:25]};
    endcase
  end

  // Quarter rounds always work on column 0 (words 0, 4, 8, 12). After the last
  // micro-step each row rotates left so the next column, or diagonal, moves in.
  always_comb begin
    word_t       col [16];
    logic [1:0]  k;
    logic [1:0]  jj;
    for (int n = 0; n < 16; n++) begin
      col[n] = w[n];
    end
    if (sub[0]) begin
      col[8] = sum;
      col[4] = mixed;
    end else begin
      col[0]  = sum;
      col[12] = mixed;
    end
    for (int i = 0; i < 4; i++) begin
      if (sub != 2'd3) begin
        k = 2'd0;
      end else if (qr == 3'd3) begin
        k = 2'(1 + i);       // diagonalise: row i ends up rotated by i
      end else if (qr == 3'd7) begin
        k = 2'(1 - i);       // undo it before the next column round
      end else begin
        k = 2'd1;
      end
      for (int j = 0; j < 4; j++) begin
        jj = 2'(j) + k;
        w_round[4*i + j] = col[4*i + int'(jj)];
      end
    end
  end

  // Feed-forward shifts the state through the adder one word a cycle
  always_comb begin
    for (int n = 0; n < 15; n++) begin
      w_ff[n] = w[n+1];
    end
    w_ff[15] = sum;
  end

  assign round_done = (sub == 2'd3) && (qr == 3'd7) && (dr == DR_W'(DOUBLE_ROUNDS - 1));

  // Keystream byte, little-endian within each word
  assign ks_word = w[byte_pos[5:2]];
  always_comb begin
    unique case (byte_pos[1:0])
      2'd0:    ks_byte = ks_word[7:0];
      2'd1:    ks_byte = ks_word[15:8];
      2'd2:    ks_byte = ks_word[23:16];
      default: ks_byte = ks_word[31:24];
    endcase
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01       <= '0;
      key_23       <= '0;
      key_45       <= '0;
      key_67       <= '0;
      nonce_low    <= '0;
      nonce_high   <= '0;
      init_counter <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_01:  key_01       <= cfg_data;
        REG_KEY_23:  key_23       <= cfg_data;
        REG_KEY_45:  key_45       <= cfg_data;
        REG_KEY_67:  key_67       <= cfg_data;
        REG_NONCE_L: nonce_low    <= cfg_data;
        REG_NONCE_H: nonce_high   <= cfg_data[31:0];
        REG_INIT_CT: init_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Working state: no reset, every block reloads it
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD:  w <= init_w;
      S_ROUND: w <= w_round;
      S_FF:    w <= w_ff;
      default: ;
    endcase
  end

  // Held transaction payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_hold <= s_tdata;
      last_hold <= s_tlast;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      block_counter <= '0;
      byte_pos      <= POS_W'(BLOCK_BYTES);
      sub           <= '0;
      qr            <= '0;
      dr            <= '0;
      ff_cnt        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // raise valid on emit, drop it once the transaction is taken
      if ((state == S_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // restart: reload the counter and drop the buffered keystream
            if (s_tuser) begin
              block_counter <= init_counter;
              byte_pos      <= POS_W'(BLOCK_BYTES);
              state         <= S_LOAD;
            end else if (byte_pos[POS_W-1]) begin
              state <= S_LOAD;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          sub   <= '0;
          qr    <= '0;
          dr    <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) begin
            qr <= qr + 3'd1;
            if (qr == 3'd7) begin
              dr <= dr + DR_W'(1);
            end
          end
          if (round_done) begin
            ff_cnt <= '0;
            state  <= S_FF;
          end
        end
        S_FF: begin
          ff_cnt <= ff_cnt + 4'd1;
          if (ff_cnt == 4'd15) begin
            block_counter <= block_counter + 32'd1;
            byte_pos      <= '0;
            state         <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the result register is free or being drained
          if (!m_tvalid || m_tready) begin
            byte_pos <= byte_pos + POS_W'(1);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= data_hold ^ ks_byte;
      m_tlast <= last_hold;
    end
  end

endmodule

`default_nettype wire
